/* src/irc_pkg.sv */
// Shared types and constants for the impulse response convolver.
// Holds field widths and the controller/datapath command and status structs.
// No dependencies.
package irc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TAP_W       = 18;
    localparam int TAP_INDEX_W = 11;
    localparam int TAP_COUNT_W = 12;
    localparam int PROD_W      = SAMPLE_W + TAP_W;
    localparam int RESP_W      = 48;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TAP    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tap_write;
        logic sample_load;
        logic issue;
        logic publish;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_last;
        logic pipe_busy;
        logic taps_zero;
        logic out_free;
    } t_ctl_sts;

endpackage

/* src/irc_datapath.sv */
// Datapath of the impulse response convolver: sample history and tap memories,
// multiply-accumulate pipeline, configuration register and output register.
// Depends on irc_pkg.
module irc_datapath
    import irc_pkg::*;
#(
    parameter int TAP_DEPTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctl_cmd                      i_cmd,
    output t_ctl_sts                      o_sts,
    input  logic signed [SAMPLE_W-1:0]    i_sample_value,
    input  logic                          i_skip_sample,
    input  logic                          i_end_of_run,
    input  logic        [TAP_INDEX_W-1:0] i_tap_index,
    input  logic signed [TAP_W-1:0]       i_tap_value,
    input  logic                          i_cfg_valid,
    input  logic        [TAP_COUNT_W-1:0] i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [RESP_W-1:0]      o_response,
    output logic                          o_ignored,
    output logic                          o_last
);

    localparam int AW = $clog2(TAP_DEPTH);
    localparam int CW = $clog2(TAP_DEPTH + 1);

    // Memories.
    logic signed [SAMPLE_W-1:0] r_history [TAP_DEPTH];
    logic signed [TAP_W-1:0]    r_taps_mem [TAP_DEPTH];

    // Control state.
    logic [TAP_COUNT_W-1:0] r_tap_count;
    logic [AW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_fill, n_fill;
    logic [AW-1:0]          r_k;
    logic [AW-1:0]          r_slot;
    logic [CW-1:0]          r_taps;
    logic                   r_skip;
    logic                   r_run_end;
    logic                   r_v1, r_v2;
    logic                   r_out_valid;

    // Payload state.
    logic                        r_hv1;
    logic signed [TAP_W-1:0]     r_tap_q;
    logic signed [SAMPLE_W-1:0]  r_hist_q;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [RESP_W-1:0]    r_acc;
    logic signed [RESP_W-1:0]    r_response;
    logic                        r_ignored;
    logic                        r_last;

    logic [TAP_COUNT_W:0]        w_count_wide;
    logic [CW-1:0]               w_sat_taps;
    logic                        w_tap_in_range;
    logic signed [SAMPLE_W-1:0]  w_sample_op;
    logic signed [SAMPLE_W-1:0]  w_hist_wdata;

    assign w_count_wide = {1'b0, r_tap_count};
    assign w_sat_taps   = (w_count_wide > (TAP_COUNT_W + 1)'(TAP_DEPTH)) ?
                          CW'(TAP_DEPTH) : CW'(w_count_wide);
    assign w_tap_in_range = (int'(i_tap_index) < TAP_DEPTH);
    assign n_pos  = (r_pos == AW'(TAP_DEPTH - 1)) ? '0 : r_pos + AW'(1);
    assign n_fill = (r_fill == CW'(TAP_DEPTH)) ? r_fill : r_fill + CW'(1);
    assign w_hist_wdata = i_skip_sample ? '0 : i_sample_value;
    // History slots older than the current run read as zero.
    assign w_sample_op  = r_hv1 ? r_hist_q : '0;

    assign o_sts.issue_last = ((CW'(r_k) + CW'(1)) == r_taps);
    assign o_sts.pipe_busy  = r_v1 | r_v2;
    assign o_sts.taps_zero  = (r_tap_count == '0);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_load) begin
            r_history[n_pos] <= w_hist_wdata;
        end
        if (i_cmd.issue) begin
            r_hist_q <= r_history[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_write && w_tap_in_range) begin
            r_taps_mem[AW'(i_tap_index)] <= i_tap_value;
        end
        if (i_cmd.issue) begin
            r_tap_q <= r_taps_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_W'(1);
            r_pos       <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_slot      <= '0;
            r_taps      <= '0;
            r_skip      <= 1'b0;
            r_run_end   <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tap_count <= i_cfg_data;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.sample_load) begin
                r_pos     <= n_pos;
                r_fill    <= n_fill;
                r_k       <= '0;
                r_slot    <= n_pos;
                r_taps    <= w_sat_taps;
                r_skip    <= i_skip_sample;
                r_run_end <= i_end_of_run;
            end else if (i_cmd.issue) begin
                r_k    <= r_k + AW'(1);
                r_slot <= (r_slot == '0) ? AW'(TAP_DEPTH - 1) : r_slot - AW'(1);
            end
            // The end of a run restarts the history with zero stored samples.
            if (i_cmd.publish && r_run_end) begin
                r_pos  <= '0;
                r_fill <= '0;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_hv1 <= (CW'(r_k) < r_fill);
        end
        if (r_v1) begin
            r_prod <= r_tap_q * w_sample_op;
        end
        if (i_cmd.sample_load) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(RESP_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_cmd.publish) begin
            r_response <= r_skip ? '0 : r_acc;
            r_ignored  <= r_skip;
            r_last     <= r_run_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_response  = r_response;
    assign o_ignored   = r_ignored;
    assign o_last      = r_last;

endmodule

/* src/irc_controller.sv */
// Controller state machine of the impulse response convolver.
// Sequences tap writes, the multiply-accumulate sweep, drain and result hand-off.
// Depends on irc_pkg.
module irc_controller
    import irc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic     i_mode,
    input  logic     i_skip_sample,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.tap_write   = w_accept && (i_mode == MODE_TAP);
        o_cmd.sample_load = w_accept && (i_mode == MODE_SAMPLE);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.sample_load) begin
                    // Skipped samples and an empty tap set need no sweep.
                    if (i_skip_sample || i_sts.taps_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_sts.out_free)
        else $error("result published while the output register is occupied");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !i_sts.pipe_busy)
        else $error("result stage reached with products still in flight");

    a_run_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && i_sts.issue_last) |=> (r_state == S_DRAIN))
        else $error("sweep did not stop after the last tap");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.sample_load || o_cmd.tap_write) |=> $past(r_state == S_IDLE))
        else $error("input transaction taken outside the idle state");

endmodule

/* src/impulse_response_convolver_unit.sv */
// Impulse response convolver: top level joining controller and datapath.
// A coefficient write leaves the block idle; it is ready again in the next cycle.
// A sample sweeps the taps through the single multiply-accumulate unit, drains its pipeline
// and publishes its result once the output register is free; the input stalls until then.
// A skipped sample or a tap count of zero needs no sweep and goes straight to its result.
// Synchronous active-low reset clears control state; tap memory is undefined.
module impulse_response_convolver_unit
    import irc_pkg::*;
#(
    parameter int TAP_DEPTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic signed [SAMPLE_W-1:0]    i_sample_value,
    input  logic                          i_skip_sample,
    input  logic                          i_end_of_run,
    input  logic        [TAP_INDEX_W-1:0] i_tap_index,
    input  logic signed [TAP_W-1:0]       i_tap_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [RESP_W-1:0]      o_response,
    output logic                          o_ignored,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [TAP_COUNT_W-1:0] i_cfg_data
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    // The tap count register can always take a write.
    assign o_cfg_ready = 1'b1;

    irc_controller u_controller (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_skip_sample (i_skip_sample),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    irc_datapath #(
        .TAP_DEPTH (TAP_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample_value (i_sample_value),
        .i_skip_sample  (i_skip_sample),
        .i_end_of_run   (i_end_of_run),
        .i_tap_index    (i_tap_index),
        .i_tap_value    (i_tap_value),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_response     (o_response),
        .o_ignored      (o_ignored),
        .o_last         (o_last)
    );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for impulse_response_convolver_unit: drives samples and coefficient
// writes, predicts each convolved response and checks every result transaction in order.
// Depends on irc_pkg and the convolver RTL in src.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irc_pkg::*;

    localparam int TAPS        = 2048;
    localparam int LONG_TAPS   = 64;
    localparam int SETTLE      = 8;
    localparam int TAIL_CYCLES = 32;
    localparam int DRAIN_LIMIT = 200000;
    localparam int BATCHES     = 4;
    localparam int BATCH_ITEMS = 15;

    typedef struct {
        logic                          mode;
        logic signed [SAMPLE_W-1:0]    sample;
        logic                          skip;
        logic                          last;
        logic        [TAP_INDEX_W-1:0] tap_index;
        logic signed [TAP_W-1:0]       tap_value;
    } t_stim;

    typedef struct {
        logic signed [RESP_W-1:0] response;
        logic                     ignored;
        logic                     last;
    } t_response;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_mode;
    logic signed [SAMPLE_W-1:0]    i_sample_value;
    logic                          i_skip_sample;
    logic                          i_end_of_run;
    logic        [TAP_INDEX_W-1:0] i_tap_index;
    logic signed [TAP_W-1:0]       i_tap_value;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [RESP_W-1:0]      o_response;
    logic                          o_ignored;
    logic                          o_last;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic        [TAP_COUNT_W-1:0] i_cfg_data;

    // Predicted state of the convolver.
    logic signed [SAMPLE_W-1:0]    history [TAPS];
    logic signed [TAP_W-1:0]       coeffs  [TAPS];
    logic        [TAP_INDEX_W-1:0] newest_slot;
    logic        [TAP_COUNT_W-1:0] active_taps;

    t_response pending_responses[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_request;
    int mismatch_count;
    int samples_sent;
    int skipped_sent;
    int runs_ended;
    int coeff_writes;
    int tap_count_writes;
    int responses_checked;
    int longest_input_stall;

    impulse_response_convolver_unit #(
        .TAP_DEPTH(TAPS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_sample_value (i_sample_value),
        .i_skip_sample  (i_skip_sample),
        .i_end_of_run   (i_end_of_run),
        .i_tap_index    (i_tap_index),
        .i_tap_value    (i_tap_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_response     (o_response),
        .o_ignored      (o_ignored),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void clear_history();
        for (int i = 0; i < TAPS; i++) history[i] = '0;
        newest_slot = '0;
    endfunction

    // Applies one accepted input transaction to the predicted state and queues the
    // response that it must produce.
    function automatic void predict_response(input t_stim it);
        t_response want;
        longint    acc;
        int        n;
        if (it.mode == MODE_TAP) begin
            coeffs[it.tap_index] = it.tap_value;
            return;
        end
        newest_slot = newest_slot + 1'b1;
        history[newest_slot] = it.skip ? '0 : it.sample;
        n = (active_taps > TAPS) ? TAPS : int'(active_taps);
        acc = 0;
        if (!it.skip) begin
            for (int k = 0; k < n; k++)
                acc += longint'(coeffs[k]) * longint'(history[TAP_INDEX_W'(newest_slot - k)]);
        end
        want.response = acc[RESP_W-1:0];
        want.ignored  = it.skip;
        want.last     = it.last;
        pending_responses.push_back(want);
        if (it.last) clear_history();
    endfunction

    function automatic t_stim make_sample(input logic signed [SAMPLE_W-1:0] value,
                                          input logic skip, input logic last);
        t_stim it;
        it.mode      = MODE_SAMPLE;
        it.sample    = value;
        it.skip      = skip;
        it.last      = last;
        it.tap_index = TAP_INDEX_W'($urandom);
        it.tap_value = TAP_W'($urandom);
        return it;
    endfunction

    function automatic t_stim make_tap(input logic [TAP_INDEX_W-1:0] index,
                                       input logic signed [TAP_W-1:0] value);
        t_stim it;
        it.mode      = MODE_TAP;
        it.sample    = SAMPLE_W'($urandom);
        it.skip      = 1'($urandom);
        it.last      = 1'($urandom);
        it.tap_index = index;
        it.tap_value = value;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample_value();
        int r;
        r = $urandom_range(99);
        if (r < 10) return {1'b1, {(SAMPLE_W-1){1'b0}}};
        if (r < 20) return {1'b0, {(SAMPLE_W-1){1'b1}}};
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic signed [TAP_W-1:0] random_tap_value();
        int r;
        r = $urandom_range(99);
        if (r < 10) return {1'b1, {(TAP_W-1){1'b0}}};
        if (r < 20) return {1'b0, {(TAP_W-1){1'b1}}};
        return TAP_W'($urandom);
    endfunction

    // Called at a falling edge. Returns at the falling edge after the transaction, with
    // valid still high so that a following item can follow without a gap.
    task automatic send_item(input t_stim it);
        int stall_run;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= it.mode;
        i_sample_value <= it.sample;
        i_skip_sample  <= it.skip;
        i_end_of_run   <= it.last;
        i_tap_index    <= it.tap_index;
        i_tap_value    <= it.tap_value;
        stall_run = 0;
        forever begin
            @(posedge i_clk);
            if (o_in_stall === 1'b0) break;
            stall_run++;
        end
        if (stall_run > longest_input_stall) longest_input_stall = stall_run;
        predict_response(it);
        if (it.mode == MODE_TAP) begin
            coeff_writes++;
        end else begin
            samples_sent++;
            if (it.skip) skipped_sent++;
            if (it.last) runs_ended++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        int waited;
        waited = 0;
        while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_responses.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_responses.size()));
    endtask

    // The register is only written with the block idle: all responses back and the
    // last coefficient write given time to settle.
    task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] value);
        i_in_valid <= 1'b0;
        wait_until_drained();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        active_taps = value;
        tap_count_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_default();
        send_item(make_tap('0, {1'b0, {(TAP_W-1){1'b1}}}));
        send_item(make_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0, 1'b0));
        send_item(make_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0, 1'b0));
        send_item(make_sample(16'sd0, 1'b0, 1'b0));
        send_item(make_sample(16'sd1234, 1'b1, 1'b0));
    endtask

    task automatic test_directed_extremes();
        for (int i = 1; i < 8; i++)
            send_item(make_tap(TAP_INDEX_W'(i),
                               (i % 2) ? {1'b1, {(TAP_W-1){1'b0}}} : {1'b0, {(TAP_W-1){1'b1}}}));
        write_tap_count(TAP_COUNT_W'(8));
        send_item(make_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0, 1'b0));
        send_item(make_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0, 1'b0));
        send_item(make_sample(-16'sd1, 1'b1, 1'b0));
        send_item(make_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0, 1'b1));
        // A new run must see an empty history.
        send_item(make_sample(16'sd77, 1'b0, 1'b0));
        send_item(make_sample(-16'sd300, 1'b1, 1'b1));
        write_tap_count('0);
        send_item(make_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0, 0));
        send_item(make_sample(16'sd5, 1'b1, 1'b1));
    endtask

    // Loads a longer impulse response; later random tap counts stay within it.
    task automatic test_long_response();
        send_item(make_tap('0, {1'b1, {(TAP_W-1){1'b0}}}));
        for (int i = 8; i < LONG_TAPS; i++)
            send_item(make_tap(TAP_INDEX_W'(i), random_tap_value()));
        write_tap_count(TAP_COUNT_W'(LONG_TAPS));
        for (int i = 0; i < 3; i++)
            send_item(make_sample(random_sample_value(), 1'b0, 1'b0));
        send_item(make_sample(random_sample_value(), 1'b0, 1'b1));
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct);
        int    r;
        t_stim it;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int b = 0; b < BATCHES; b++) begin
            r = $urandom_range(99);
            if (r < 5)       write_tap_count('0);
            else if (r < 80) write_tap_count(TAP_COUNT_W'($urandom_range(1, 16)));
            else if (r < 95) write_tap_count(TAP_COUNT_W'($urandom_range(17, 48)));
            else             write_tap_count(TAP_COUNT_W'($urandom_range(49, LONG_TAPS)));
            for (int i = 0; i < BATCH_ITEMS; i++) begin
                r = $urandom_range(99);
                if (r < 20)
                    it = make_tap(TAP_INDEX_W'($urandom_range(0, 31)), random_tap_value());
                else if (r < 25)
                    it = make_tap(TAP_INDEX_W'($urandom), random_tap_value());
                else
                    it = make_sample(random_sample_value(), $urandom_range(99) < 15,
                                     $urandom_range(99) < 6);
                send_item(it);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(24, 77);
        run_random_phase(77, 24);
        run_random_phase(0, 0);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tap_count(TAP_COUNT_W'(3));
        hold_off_request = 300;
        for (int i = 0; i < 24; i++)
            send_item(make_sample(random_sample_value(), $urandom_range(99) < 15, i == 23));
    endtask

    // Receiver side: random stalls plus any requested long hold-off.
    initial begin : receiver_stall
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request > 0) begin
                hold_left        = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : response_checker
        t_response want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_responses.size() == 0) begin
                    report_mismatch("response transaction with no sample outstanding");
                end else begin
                    want = pending_responses.pop_front();
                    responses_checked++;
                    if (o_response !== want.response)
                        report_mismatch($sformatf("response %0d, expected %0d",
                                                  o_response, want.response));
                    if (o_ignored !== want.ignored)
                        report_mismatch($sformatf("ignored %b, expected %b",
                                                  o_ignored, want.ignored));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                end
            end
        end
    end

    initial begin : main_sequence
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_mode           = MODE_SAMPLE;
        i_sample_value   = '0;
        i_skip_sample    = 1'b0;
        i_end_of_run     = 1'b0;
        i_tap_index      = '0;
        i_tap_value      = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        send_idle_pct    = 24;
        recv_idle_pct    = 77;
        hold_off_request = 0;
        mismatch_count   = 0;
        for (int i = 0; i < TAPS; i++) coeffs[i] = '0;
        clear_history();
        active_taps = TAP_COUNT_W'(1);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_default();
        test_directed_extremes();
        test_long_response();
        test_random_traffic();
        test_back_pressure();

        i_in_valid <= 1'b0;
        wait_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d samples (%0d skipped, %0d ends of run), %0d coefficient writes",
                 samples_sent, skipped_sent, runs_ended, coeff_writes);
        $display("and %0d tap count settings; %0d responses checked, longest input stall %0d",
                 tap_count_writes, responses_checked, longest_input_stall);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
